// ----- rtl/atfcb_pkg.sv -----
package atfcb_pkg;

  localparam int ADDR_W = 28;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FLUSH = 2'd2,
    OP_OTHER = 2'd3
  } op_t;

  localparam logic [2:0] REG_LBA_MODE    = 3'd0;
  localparam logic [2:0] REG_DRIVE       = 3'd1;
  localparam logic [2:0] REG_HEADS       = 3'd2;
  localparam logic [2:0] REG_SPT         = 3'd3;
  localparam logic [2:0] REG_FLUSH_SUP   = 3'd4;
  localparam logic [2:0] REG_CACHE_KNOWN = 3'd5;
  localparam logic [2:0] REG_CACHE_EN    = 3'd6;

  localparam logic [7:0] CMD_NONE  = 8'h00;
  localparam logic [7:0] CMD_READ  = 8'h20;
  localparam logic [7:0] CMD_WRITE = 8'h30;
  localparam logic [7:0] CMD_FLUSH = 8'he7;
  localparam logic [7:0] DEV_BASE  = 8'ha0;
  localparam logic [7:0] DEV_LBA   = 8'h40;

  // request fields carried along the divider chain
  typedef struct packed {
    op_t               op;
    logic [7:0]        count;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        r1;
  } req_t;

  // contents of one divider cell
  typedef struct packed {
    logic              valid;
    req_t              req;
    logic [7:0]        rem;
    logic [ADDR_W-1:0] dvd;
  } cell_t;

endpackage

// ----- rtl/atfcb_div_cell.sv -----
module atfcb_div_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic [7:0]         divisor,
  input  atfcb_pkg::cell_t   din,
  output atfcb_pkg::cell_t   dout
);

  logic [8:0] trial;
  logic [8:0] diff;
  logic       qbit;
  atfcb_pkg::cell_t nxt;

  // shift in one dividend bit and try the subtract
  always_comb begin
    trial = {din.rem, din.dvd[atfcb_pkg::ADDR_W-1]};
    diff  = trial - {1'b0, divisor};
    qbit  = (trial >= {1'b0, divisor});
    nxt       = din;
    nxt.rem   = qbit ? diff[7:0] : trial[7:0];
    nxt.dvd   = {din.dvd[atfcb_pkg::ADDR_W-2:0], qbit};
  end

  // advance the payload; clear the valid bit under reset
  always_ff @(posedge clk) begin
    if (en) begin
      dout.req <= nxt.req;
      dout.rem <= nxt.rem;
      dout.dvd <= nxt.dvd;
    end
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
  end

endmodule

// ----- rtl/ata_task_file_command_builder.sv -----
// Channel   Direction  Handshake             Payload
// request   in         in_valid / in_stall   op, block_address, block_count
// result    out        out_valid / out_stall issue, command_code, device_head,
//                                            xfer_count, addr_low/mid/high, status
// config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle while the result is not stalled; two chains of 28 divider cells
// (address by sectors per track, then quotient by heads) plus an output register.
// Synchronous active-high reset clears valid bits and sets register defaults.
// A stalled result freezes the whole chain; in_stall follows it.
module ata_task_file_command_builder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [27:0] block_address,
  input  logic [7:0]  block_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        issue,
  output logic [7:0]  command_code,
  output logic [7:0]  device_head,
  output logic [7:0]  xfer_count,
  output logic [7:0]  addr_low,
  output logic [7:0]  addr_mid,
  output logic [7:0]  addr_high,
  output logic        status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int NCELL = 2 * atfcb_pkg::ADDR_W;

  logic       lba_mode;
  logic       drive_index;
  logic [4:0] heads_per_cylinder;
  logic [7:0] track_sectors;
  logic       flush_capable;
  logic       cache_state_known;
  logic       cache_enabled;

  logic [7:0] spt_eff;
  logic [7:0] hds_eff;
  logic       en;

  atfcb_pkg::cell_t chain_in  [NCELL];
  atfcb_pkg::cell_t chain_out [NCELL];

  logic       issue_next;
  logic [7:0] cmd_next;
  logic [7:0] dev_next;
  logic [7:0] cnt_next;
  logic [7:0] lo_next;
  logic [7:0] mid_next;
  logic [7:0] hi_next;
  logic       status_next;

  assign cfg_ready = 1'b1;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lba_mode           <= 1'b0;
      drive_index        <= 1'b0;
      heads_per_cylinder <= 5'd16;
      track_sectors      <= 8'd63;
      flush_capable      <= 1'b0;
      cache_state_known  <= 1'b0;
      cache_enabled      <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        atfcb_pkg::REG_LBA_MODE:    lba_mode           <= cfg_data[0];
        atfcb_pkg::REG_DRIVE:       drive_index        <= cfg_data[0];
        atfcb_pkg::REG_HEADS:       heads_per_cylinder <= cfg_data[4:0];
        atfcb_pkg::REG_SPT:         track_sectors      <= cfg_data;
        atfcb_pkg::REG_FLUSH_SUP:   flush_capable      <= cfg_data[0];
        atfcb_pkg::REG_CACHE_KNOWN: cache_state_known  <= cfg_data[0];
        atfcb_pkg::REG_CACHE_EN:    cache_enabled      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // treat zero geometry as one
  assign spt_eff = (track_sectors == 8'd0) ? 8'd1 : track_sectors;
  assign hds_eff = (heads_per_cylinder == 5'd0) ? 8'd1 : {3'd0, heads_per_cylinder};

  // freeze everything while a result is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // feed the first cell
  always_comb begin
    chain_in[0].valid     = in_valid;
    chain_in[0].req.op    = atfcb_pkg::op_t'(op);
    chain_in[0].req.count = block_count;
    chain_in[0].req.addr  = block_address;
    chain_in[0].req.r1    = 8'd0;
    chain_in[0].rem       = 8'd0;
    chain_in[0].dvd       = block_address;
  end

  // link cells; keep the first remainder and restart the remainder between the two divisions
  for (genvar g = 1; g < NCELL; g++) begin : g_link
    if (g == atfcb_pkg::ADDR_W) begin : g_turn
      always_comb begin
        chain_in[g]        = chain_out[g-1];
        chain_in[g].req.r1 = chain_out[g-1].rem;
        chain_in[g].rem    = 8'd0;
      end
    end else begin : g_pass
      assign chain_in[g] = chain_out[g-1];
    end
  end

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    atfcb_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .divisor ((g < atfcb_pkg::ADDR_W) ? spt_eff : hds_eff),
      .din     (chain_in[g]),
      .dout    (chain_out[g])
    );
  end

  // build the task file from the last cell
  always_comb begin
    atfcb_pkg::cell_t   c;
    c           = chain_out[NCELL-1];
    issue_next  = 1'b0;
    cmd_next    = atfcb_pkg::CMD_NONE;
    dev_next    = 8'd0;
    cnt_next    = 8'd0;
    lo_next     = 8'd0;
    mid_next    = 8'd0;
    hi_next     = 8'd0;
    status_next = 1'b0;
    case (c.req.op) inside
      atfcb_pkg::OP_READ, atfcb_pkg::OP_WRITE: begin
        if (c.req.count != 8'd0) begin
          issue_next = 1'b1;
          cmd_next   = (c.req.op == atfcb_pkg::OP_READ) ? atfcb_pkg::CMD_READ
                                                        : atfcb_pkg::CMD_WRITE;
          cnt_next   = c.req.count;
          if (lba_mode) begin
            dev_next = atfcb_pkg::DEV_BASE | atfcb_pkg::DEV_LBA |
                       {3'd0, drive_index, c.req.addr[27:24]};
            lo_next  = c.req.addr[7:0];
            mid_next = c.req.addr[15:8];
            hi_next  = c.req.addr[23:16];
          end else begin
            dev_next = atfcb_pkg::DEV_BASE | {3'd0, drive_index, c.rem[3:0]};
            lo_next  = c.req.r1 + 8'd1;
            mid_next = c.dvd[7:0];
            hi_next  = c.dvd[15:8];
          end
        end
      end
      atfcb_pkg::OP_FLUSH: begin
        if (flush_capable) begin
          issue_next = 1'b1;
          cmd_next   = atfcb_pkg::CMD_FLUSH;
          dev_next   = atfcb_pkg::DEV_BASE | (lba_mode ? atfcb_pkg::DEV_LBA : 8'd0) |
                       {3'd0, drive_index, 4'd0};
        end else begin
          status_next = !(cache_state_known && !cache_enabled);
        end
      end
      default: status_next = 1'b1;
    endcase
  end

  // hold the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= chain_out[NCELL-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      issue        <= issue_next;
      command_code <= cmd_next;
      device_head  <= dev_next;
      xfer_count   <= cnt_next;
      addr_low     <= lo_next;
      addr_mid     <= mid_next;
      addr_high    <= hi_next;
      status       <= status_next;
    end
  end

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(device_head))
    else $error("result lost under stall");

  a_issue_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && issue |-> !status && command_code != atfcb_pkg::CMD_NONE)
    else $error("issued command with bad status");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !issue |-> command_code == atfcb_pkg::CMD_NONE && device_head == 8'd0)
    else $error("fields set without issue");

endmodule
